// ----- rtl/multiplexed_seven_segment_clock_unit_defines.svh -----
// assertion macros for the seven-segment clock unit
`ifndef MULTIPLEXED_SEVEN_SEGMENT_CLOCK_UNIT_DEFINES_SVH
`define MULTIPLEXED_SEVEN_SEGMENT_CLOCK_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define MSSC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define MSSC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define MSSC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define MSSC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- rtl/mssc_pkg.sv -----
// types, constants and helper functions of the seven-segment clock unit
package mssc_pkg;

  localparam int unsigned Digits  = 4;
  localparam int unsigned PeriodW = 10;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned PosW    = 2;
  localparam int unsigned SegW    = 7;
  localparam int unsigned EnW     = Digits;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinW    = 6;
  localparam int unsigned SecW    = 6;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [PeriodW-1:0] period_t;
  typedef logic [DigitW-1:0]  digit_t;
  typedef digit_t [Digits-1:0] digit_store_t;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgSecondPeriod = 2'd0,
    CfgBlinkPeriod  = 2'd1,
    CfgScanPeriod   = 2'd2
  } cfg_idx_e;

  localparam period_t SecondPeriodRst = 10'd100;
  localparam period_t BlinkPeriodRst  = 10'd100;
  localparam period_t ScanPeriodRst   = 10'd25;

  localparam logic [SecW-1:0]  SecRst   = 6'd50;
  localparam logic [MinW-1:0]  MinRst   = 6'd8;
  localparam logic [HourW-1:0] HourRst  = 5'd15;
  localparam logic [SecW-1:0]  SecWrap  = 6'd60;
  localparam logic [MinW-1:0]  MinWrap  = 6'd60;
  localparam logic [HourW-1:0] HourWrap = 5'd24;

  // digit 0 is the leftmost (hour tens)
  localparam digit_store_t DigitRst = {4'd8, 4'd0, 4'd5, 4'd1};

  // events of one tick, in handling order
  typedef struct packed {
    logic second;
    logic blink;
    logic scan;
  } tick_events_t;

  typedef struct packed {
    period_t count;
    logic    fire;
  } countdown_t;

  typedef struct packed {
    digit_t tens;
    digit_t units;
  } digit_pair_t;

  // reloading countdown: a zero count stays put and never fires
  function automatic countdown_t countdown_step(period_t cnt, period_t period);
    countdown_t res;
    period_t    dec;
    dec      = cnt - period_t'(1);
    res.fire = 1'b0;
    res.count = cnt;
    if (cnt != '0) begin
      if (dec == '0) begin
        res.fire  = 1'b1;
        res.count = period;
      end else begin
        res.count = dec;
      end
    end
    return res;
  endfunction

  // tens and units of a value below sixty
  function automatic digit_pair_t split_digits(logic [MinW-1:0] v);
    digit_pair_t res;
    logic [MinW-1:0] base;
    if (v >= 6'd50) begin
      res.tens = 4'd5;
      base     = 6'd50;
    end else if (v >= 6'd40) begin
      res.tens = 4'd4;
      base     = 6'd40;
    end else if (v >= 6'd30) begin
      res.tens = 4'd3;
      base     = 6'd30;
    end else if (v >= 6'd20) begin
      res.tens = 4'd2;
      base     = 6'd20;
    end else if (v >= 6'd10) begin
      res.tens = 4'd1;
      base     = 6'd10;
    end else begin
      res.tens = 4'd0;
      base     = 6'd0;
    end
    res.units = digit_t'(v - base);
    return res;
  endfunction

  // active-low segment pattern, segment a in bit 0
  function automatic logic [SegW-1:0] seg_pattern(digit_t d);
    logic [SegW-1:0] p;
    case (d)
      4'd0:    p = 7'b1000000;
      4'd1:    p = 7'b1111001;
      4'd2:    p = 7'b0100100;
      4'd3:    p = 7'b0110000;
      4'd4:    p = 7'b0011001;
      4'd5:    p = 7'b0010010;
      4'd6:    p = 7'b0000010;
      4'd7:    p = 7'b1111000;
      4'd8:    p = 7'b0000000;
      4'd9:    p = 7'b0010000;
      default: p = 7'b1111111;
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/mssc_if.sv -----
// valid/ready channel interfaces of the seven-segment clock unit
interface mssc_in_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink (input valid, input tick, output ready);
endinterface

interface mssc_out_if import mssc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [SegW-1:0]  segments;
  logic [EnW-1:0]   digit_enable;
  logic             colon;
  logic [HourW-1:0] hours;
  logic [MinW-1:0]  minutes;
  logic [SecW-1:0]  seconds;

  modport source (output valid, output segments, output digit_enable, output colon,
                  output hours, output minutes, output seconds, input ready);
  modport sink (input valid, input segments, input digit_enable, input colon,
                input hours, input minutes, input seconds, output ready);
endinterface

// ----- rtl/multiplexed_seven_segment_clock_unit.sv -----
// top level of the multiplexed four-digit seven-segment clock
//
// in_i carries one tick per transaction; every accepted transaction yields
// exactly one result transaction on out_o with the segment pattern, the
// active-low digit enable, the colon level and the current hh:mm:ss.
// A tick of 0 still yields a result, with the state unchanged.
// The three countdown periods are written through cfg_we_i / cfg_idx_i /
// cfg_wdata_i; the user must write them only while the unit is idle (the
// block does not enforce this); a new period takes effect at the next
// reload of its countdown. From acceptance to the valid result: the input
// register, then the state update into the result register. Throughput:
// one transaction per cycle while out_o does not stall; the per-tick
// state update is a single pass of countdown, time and scan logic between
// the two registers. When out_o stalls, the result register holds and one
// more transaction can sit in the input register; in_i.ready then drops.
// Reset shows 15:08:50, loads default periods 100/100/25 and leaves the
// segment and enable latches and the colon at 0.
`include "multiplexed_seven_segment_clock_unit_defines.svh"

module multiplexed_seven_segment_clock_unit import mssc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [PeriodW-1:0] cfg_wdata_i,
  mssc_in_if.sink            in_i,
  mssc_out_if.source         out_o
);

  period_t second_period_q, blink_period_q, scan_period_q;
  period_t second_cnt_q, blink_cnt_q, scan_cnt_q;
  period_t second_cnt_d, blink_cnt_d, scan_cnt_d;
  countdown_t   second_cd, blink_cd, scan_cd;
  tick_events_t events;

  logic s1_valid_q, s1_tick_q;
  logic advance, step, in_ready;
  logic out_valid_q;

  logic [SegW-1:0]  seg_d, seg_q;
  logic [EnW-1:0]   en_d, en_q;
  logic             colon_d, colon_q;
  logic [HourW-1:0] hours_d, hours_q;
  logic [MinW-1:0]  minutes_d, minutes_q;
  logic [SecW-1:0]  seconds_d, seconds_q;
  digit_store_t     digits;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_period_q <= SecondPeriodRst;
      blink_period_q  <= BlinkPeriodRst;
      scan_period_q   <= ScanPeriodRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgSecondPeriod: second_period_q <= cfg_wdata_i;
        CfgBlinkPeriod:  blink_period_q  <= cfg_wdata_i;
        CfgScanPeriod:   scan_period_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pipeline handshake: input register feeds the result register
  assign advance  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !s1_valid_q || advance;
  assign step     = advance && s1_tick_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      s1_tick_q <= in_i.tick;
    end
  end

  // three reloading countdowns
  always_comb begin
    second_cd    = countdown_step(second_cnt_q, second_period_q);
    blink_cd     = countdown_step(blink_cnt_q, blink_period_q);
    scan_cd      = countdown_step(scan_cnt_q, scan_period_q);
    events.second = step && second_cd.fire;
    events.blink  = step && blink_cd.fire;
    events.scan   = step && scan_cd.fire;
    second_cnt_d = step ? second_cd.count : second_cnt_q;
    blink_cnt_d  = step ? blink_cd.count : blink_cnt_q;
    scan_cnt_d   = step ? scan_cd.count : scan_cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_cnt_q <= SecondPeriodRst;
      blink_cnt_q  <= BlinkPeriodRst;
      scan_cnt_q   <= ScanPeriodRst;
    end else begin
      second_cnt_q <= second_cnt_d;
      blink_cnt_q  <= blink_cnt_d;
      scan_cnt_q   <= scan_cnt_d;
    end
  end

  mssc_time u_time (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (events.second),
    .hours_o   (hours_d),
    .minutes_o (minutes_d),
    .seconds_o (seconds_d),
    .digits_o  (digits)
  );

  mssc_display u_display (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .events_i   (events),
    .digits_i   (digits),
    .segments_o (seg_d),
    .enable_o   (en_d),
    .colon_o    (colon_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      seg_q     <= seg_d;
      en_q      <= en_d;
      colon_q   <= colon_d;
      hours_q   <= hours_d;
      minutes_q <= minutes_d;
      seconds_q <= seconds_d;
    end
  end

  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.segments     = seg_q;
  assign out_o.digit_enable = en_q;
  assign out_o.colon        = colon_q;
  assign out_o.hours        = hours_q;
  assign out_o.minutes      = minutes_q;
  assign out_o.seconds      = seconds_q;

  // checks
  `MSSC_ASSERT_NXT(a_advance_gives_result, clk_i, rst_ni, advance, out_valid_q, "result lost")
  `MSSC_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, !in_ready, s1_valid_q && out_valid_q && !out_o.ready, "input stalled without a full pipeline")
  `MSSC_ASSERT_NXT(a_scan_onehot, clk_i, rst_ni, advance && events.scan, $onehot(~out_o.digit_enable), "digit enable not one-hot after scan")
  `MSSC_ASSERT_IMP(a_time_range, clk_i, rst_ni, out_valid_q, (out_o.hours <= 5'd23) && (out_o.minutes <= 6'd59) && (out_o.seconds <= 6'd59), "time out of range")

endmodule

// ----- rtl/mssc_time.sv -----
// 24-hour time counters and the four-digit store
module mssc_time import mssc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  output logic [HourW-1:0] hours_o,
  output logic [MinW-1:0]  minutes_o,
  output logic [SecW-1:0]  seconds_o,
  output digit_store_t     digits_o
);

  logic [SecW-1:0]  sec_q, sec_d;
  logic [MinW-1:0]  min_q, min_d;
  logic [HourW-1:0] hour_q, hour_d;
  digit_store_t     digits_q, digits_d;
  logic [SecW-1:0]  sec_inc;
  logic [MinW-1:0]  min_inc;
  logic [HourW-1:0] hour_inc;
  digit_pair_t      hour_split, min_split;

  // rollover chain seconds -> minutes -> hours
  always_comb begin
    sec_inc  = sec_q + SecW'(1);
    min_inc  = min_q + MinW'(1);
    hour_inc = hour_q + HourW'(1);
    sec_d    = sec_q;
    min_d    = min_q;
    hour_d   = hour_q;
    if (advance_i) begin
      if (sec_inc >= SecWrap) begin
        sec_d = '0;
        if (min_inc >= MinWrap) begin
          min_d  = '0;
          hour_d = (hour_inc >= HourWrap) ? '0 : hour_inc;
        end else begin
          min_d = min_inc;
        end
      end else begin
        sec_d = sec_inc;
      end
    end
  end

  // store refresh from the updated time
  always_comb begin
    hour_split = split_digits(MinW'(hour_d));
    min_split  = split_digits(min_d);
    digits_d   = digits_q;
    if (advance_i) begin
      digits_d[0] = hour_split.tens;
      digits_d[1] = hour_split.units;
      digits_d[2] = min_split.tens;
      digits_d[3] = min_split.units;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q    <= SecRst;
      min_q    <= MinRst;
      hour_q   <= HourRst;
      digits_q <= DigitRst;
    end else begin
      sec_q    <= sec_d;
      min_q    <= min_d;
      hour_q   <= hour_d;
      digits_q <= digits_d;
    end
  end

  assign hours_o   = hour_d;
  assign minutes_o = min_d;
  assign seconds_o = sec_d;
  assign digits_o  = digits_d;

endmodule

// ----- rtl/mssc_display.sv -----
// digit scan, segment and enable latches, colon blink
module mssc_display import mssc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tick_events_t    events_i,
  input  digit_store_t    digits_i,
  output logic [SegW-1:0] segments_o,
  output logic [EnW-1:0]  enable_o,
  output logic            colon_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [SegW-1:0] seg_q, seg_d;
  logic [EnW-1:0]  en_q, en_d;
  logic            phase_q, phase_d;
  logic            colon_q, colon_d;

  // phase toggles on the blink event and colon takes the old phase: after the first blink, lit (low) while phase is on
  always_comb begin
    phase_d = phase_q;
    colon_d = colon_q;
    if (events_i.blink) begin
      phase_d = ~phase_q;
      colon_d = phase_q;
    end
  end

  // scan event shows the current digit and moves on
  always_comb begin
    pos_d = pos_q;
    seg_d = seg_q;
    en_d  = en_q;
    if (events_i.scan) begin
      en_d  = ~(EnW'(1) << pos_q);
      seg_d = seg_pattern(digits_i[pos_q]);
      pos_d = pos_q + PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      seg_q   <= '0;
      en_q    <= '0;
      phase_q <= 1'b0;
      colon_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      seg_q   <= seg_d;
      en_q    <= en_d;
      phase_q <= phase_d;
      colon_q <= colon_d;
    end
  end

  assign segments_o = seg_d;
  assign enable_o   = en_d;
  assign colon_o    = colon_d;

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the multiplexed seven-segment clock unit
module testbench;
  import mssc_pkg::*;

  localparam int unsigned ClkHalf          = 2;
  localparam int unsigned ResetCycles      = 12;
  localparam int unsigned SettleCycles     = 6;
  localparam int unsigned DrainLimit       = 2000;
  localparam int unsigned StallCycles      = 80;
  localparam int unsigned PhaseItems       = 60;
  localparam int unsigned FastForwardTicks = 100;
  localparam int unsigned TimeoutNs        = 400_000;
  localparam int unsigned SecondsPerMinute = 60;
  localparam int unsigned MinutesPerHour   = 60;
  localparam int unsigned HoursPerDay      = 24;
  localparam period_t     PeriodMax        = 10'd1023;
  // index past the end of the register list, writes to it are dropped
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;

  typedef struct packed {
    logic [SegW-1:0]  segments;
    logic [EnW-1:0]   digit_enable;
    logic             colon;
    logic [HourW-1:0] hours;
    logic [MinW-1:0]  minutes;
    logic [SecW-1:0]  seconds;
  } display_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  period_t            cfg_wdata_i;

  mssc_in_if  in_if ();
  mssc_out_if out_if ();

  multiplexed_seven_segment_clock_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // pending ticks and displays still to come
  logic        tick_backlog[$];
  display_t    expected_displays[$];
  int unsigned items_queued;
  int unsigned items_taken;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned tick_count;
  int unsigned day_wraps;
  int unsigned scan_steps;
  int unsigned colon_toggles;
  int unsigned gap_limit;
  int unsigned tx_wait;
  int unsigned rx_wait;
  logic        stall_out;
  logic        hold_go;

  // clock model state
  period_t          second_period, blink_period, scan_period;
  period_t          second_left, blink_left, scan_left;
  logic [SecW-1:0]  sec_now;
  logic [MinW-1:0]  min_now;
  logic [HourW-1:0] hour_now;
  digit_t           shown [Digits];
  logic [PosW-1:0]  scan_slot;
  logic [SegW-1:0]  seg_now;
  logic [EnW-1:0]   enable_now;
  logic             blink_on;
  logic             colon_now;

  // active-low glyphs, segment a in bit 0, codes above nine are dark
  function automatic logic [SegW-1:0] glyph(digit_t d);
    case (d)
      4'd0:    glyph = 7'h40;
      4'd1:    glyph = 7'h79;
      4'd2:    glyph = 7'h24;
      4'd3:    glyph = 7'h30;
      4'd4:    glyph = 7'h19;
      4'd5:    glyph = 7'h12;
      4'd6:    glyph = 7'h02;
      4'd7:    glyph = 7'h78;
      4'd8:    glyph = 7'h00;
      4'd9:    glyph = 7'h10;
      default: glyph = 7'h7f;
    endcase
  endfunction

  // {fired, next count}: a zero count is stuck, reaching zero reloads
  function automatic logic [PeriodW:0] countdown_next(period_t left, period_t reload);
    period_t dec;
    dec = left - period_t'(1);
    if (left == '0) return {1'b0, left};
    if (dec != '0) return {1'b0, dec};
    return {1'b1, reload};
  endfunction

  function automatic int unsigned draw_gap();
    return (gap_limit == 0) ? 0 : $urandom_range(gap_limit, 0);
  endfunction

  function automatic period_t pick_period(int unsigned hi);
    return period_t'($urandom_range(hi, 1));
  endfunction

  // hour and minute digits shown on the four positions
  task automatic load_digits();
    shown[0] = digit_t'(hour_now / 10);
    shown[1] = digit_t'(hour_now % 10);
    shown[2] = digit_t'(min_now / 10);
    shown[3] = digit_t'(min_now % 10);
  endtask

  task automatic reset_clock_model();
    second_period = 10'd100;
    blink_period  = 10'd100;
    scan_period   = 10'd25;
    second_left   = 10'd100;
    blink_left    = 10'd100;
    scan_left     = 10'd25;
    sec_now       = 6'd50;
    min_now       = 6'd8;
    hour_now      = 5'd15;
    load_digits();
    scan_slot     = '0;
    seg_now       = '0;
    enable_now    = '0;
    blink_on      = 1'b0;
    colon_now     = 1'b0;
  endtask

  // one accepted transaction: seconds, then blink, then scan
  task automatic advance_clock(input logic tick_bit);
    logic [PeriodW:0] cd;
    display_t         shot;
    if (tick_bit) begin
      tick_count++;
      cd = countdown_next(second_left, second_period);
      second_left = cd[PeriodW-1:0];
      if (cd[PeriodW]) begin
        sec_now++;
        if (sec_now >= SecondsPerMinute) begin
          sec_now = '0;
          min_now++;
        end
        if (min_now >= MinutesPerHour) begin
          min_now = '0;
          hour_now++;
        end
        if (hour_now >= HoursPerDay) begin
          hour_now = '0;
          day_wraps++;
        end
        load_digits();
      end
      cd = countdown_next(blink_left, blink_period);
      blink_left = cd[PeriodW-1:0];
      if (cd[PeriodW]) begin
        blink_on  = !blink_on;
        colon_now = !blink_on;
        colon_toggles++;
      end
      cd = countdown_next(scan_left, scan_period);
      scan_left = cd[PeriodW-1:0];
      if (cd[PeriodW]) begin
        enable_now = ~(EnW'(1) << scan_slot);
        seg_now    = glyph(shown[scan_slot]);
        scan_slot++;
        scan_steps++;
      end
    end
    shot.segments     = seg_now;
    shot.digit_enable = enable_now;
    shot.colon        = colon_now;
    shot.hours        = hour_now;
    shot.minutes      = min_now;
    shot.seconds      = sec_now;
    expected_displays.push_back(shot);
  endtask

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // register write, only issued while the unit is idle
  task automatic write_period(input logic [CfgIdxW-1:0] idx, input period_t value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CfgSecondPeriod: second_period = value;
      CfgBlinkPeriod:  blink_period  = value;
      CfgScanPeriod:   scan_period   = value;
      default: ;
    endcase
  endtask

  task automatic set_periods(input period_t sec_p, input period_t blink_p,
                             input period_t scan_p);
    write_period(CfgSecondPeriod, sec_p);
    write_period(CfgBlinkPeriod, blink_p);
    write_period(CfgScanPeriod, scan_p);
  endtask

  task automatic queue_item(input logic tick_bit);
    tick_backlog.push_back(tick_bit);
    items_queued++;
  endtask

  task automatic queue_ticks(input int unsigned count, input int unsigned tick_pct);
    for (int unsigned k = 0; k < count; k++) queue_item($urandom_range(99, 0) < tick_pct);
  endtask

  // every queued tick accepted and every display returned
  task automatic wait_idle();
    do @(posedge clk_i);
    while (items_taken != items_queued || expected_displays.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #(ClkHalf) clk_i = ~clk_i;
  end

  // tick driver
  always @(posedge clk_i) begin : feed_ticks
    logic next_valid;
    logic next_tick;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.tick  <= 1'b0;
      tx_wait = 0;
    end else begin
      next_valid = in_if.valid;
      next_tick  = in_if.tick;
      if (in_if.valid && in_if.ready) begin
        advance_clock(in_if.tick);
        items_taken++;
        next_valid = 1'b0;
        tx_wait = draw_gap();
      end
      if (!next_valid) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (tick_backlog.size() > 0) begin
          next_valid = 1'b1;
          next_tick  = tick_backlog.pop_front();
        end
      end
      in_if.valid <= next_valid;
      in_if.tick  <= next_tick;
    end
  end

  // display monitor and checker
  always @(posedge clk_i) begin : take_displays
    display_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (expected_displays.size() == 0) begin
          flag_mismatch("display transaction with nothing expected");
        end else begin
          want = expected_displays.pop_front();
          compare_field("segments", 32'(out_if.segments), 32'(want.segments));
          compare_field("digit_enable", 32'(out_if.digit_enable),
                        32'(want.digit_enable));
          compare_field("colon", 32'(out_if.colon), 32'(want.colon));
          compare_field("hours", 32'(out_if.hours), 32'(want.hours));
          compare_field("minutes", 32'(out_if.minutes), 32'(want.minutes));
          compare_field("seconds", 32'(out_if.seconds), 32'(want.seconds));
        end
        rx_wait = draw_gap();
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_if.ready <= (rx_wait == 0) && !stall_out;
    end
  end

  // long output hold-off so the unit backs up into its input
  initial begin : hold_results
    stall_out = 1'b0;
    wait (hold_go);
    @(posedge clk_i);
    stall_out <= 1'b1;
    repeat (StallCycles) @(posedge clk_i);
    stall_out <= 1'b0;
  end

  // stimulus phases
  initial begin : run_phases
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgSecondPeriod;
    cfg_wdata_i   = '0;
    in_if.valid   = 1'b0;
    in_if.tick    = 1'b0;
    out_if.ready  = 1'b0;
    gap_limit     = 19;
    hold_go       = 1'b0;
    items_queued  = 0;
    items_taken   = 0;
    results_seen  = 0;
    mismatches    = 0;
    tick_count    = 0;
    day_wraps     = 0;
    scan_steps    = 0;
    colon_toggles = 0;
    reset_clock_model();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // new periods only land at the next reload; spare index is ignored
    set_periods(10'd2, 10'd1, 10'd3);
    write_period(CfgIdxSpare, period_t'($urandom_range(1023, 0)));

    // directed: a tick-free transaction, enough ticks for the first scan step, then another tick-free one
    queue_item(1'b0);
    for (int unsigned k = 0; k < 25; k++) queue_item(1'b1);
    queue_item(1'b0);
    wait_idle();

    // random phases with short periods
    for (int unsigned p = 0; p < 4; p++) begin
      set_periods(pick_period(6), pick_period(4), pick_period(3));
      if (p == 3) write_period(CfgIdxSpare, period_t'($urandom_range(1023, 0)));
      gap_limit <= (p == 1 || p == 2) ? 0 : 19;
      if (p == 2) hold_go = 1'b1;
      queue_ticks(PhaseItems, 80);
      wait_idle();
    end

    // fast run through a minute rollover, slowest blink and scan
    set_periods(10'd1, PeriodMax, PeriodMax);
    gap_limit <= 0;
    queue_ticks(FastForwardTicks, 98);
    wait_idle();

    // slowest seconds, fastest blink and scan
    set_periods(PeriodMax, 10'd1, 10'd1);
    gap_limit <= 19;
    queue_ticks(PhaseItems, 90);
    wait_idle();

    // zero periods: a countdown that still reaches zero fires once more and then stays at zero
    set_periods(10'd0, 10'd0, 10'd0);
    queue_ticks(80, 90);
    do @(posedge clk_i);
    while (items_taken != items_queued);
    for (int unsigned c = 0; c < DrainLimit && expected_displays.size() != 0; c++)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    while (expected_displays.size() != 0) begin
      void'(expected_displays.pop_front());
      flag_mismatch("expected display never arrived");
    end

    $display("covered %0d transactions, %0d ticks, %0d scan steps, %0d colon toggles",
             results_seen, tick_count, scan_steps, colon_toggles);
    $display("%0d day wraps, periods 0 to 1023, one %0d-cycle output stall, %0d mismatches",
             day_wraps, StallCycles, mismatches);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #(TimeoutNs);
    $display("timeout after %0d ns with %0d displays outstanding", TimeoutNs,
             expected_displays.size());
    $display("testbench: FAIL");
    $finish;
  end

endmodule

// ----- multiplexed_seven_segment_clock_unit.f -----
+incdir+rtl
rtl/mssc_pkg.sv
rtl/mssc_if.sv
rtl/mssc_time.sv
rtl/mssc_display.sv
rtl/multiplexed_seven_segment_clock_unit.sv
dv/testbench.sv
